FILE: hdl/lpd_pkg.sv
// Package with shared types and constants for the length-prefixed packet deframer.
package lpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned WordW = 64;

  localparam logic [LenW-1:0] MaxLenReset = 16'd29000;

  typedef enum logic [1:0] {
    EV_HDR_OK  = 2'd0,
    EV_BODY    = 2'd1,
    EV_HDR_BAD = 2'd2
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e         kind;
    logic [ByteW-1:0] data;
    logic [WordW-1:0] word;
    logic [LenW-1:0]  len;
    logic             last;
  } res_t;

endpackage

FILE: hdl/length_prefixed_packet_deframer_unit.sv
// A byte accepted at the input passes the input register and then the result register.
// Throughput: one byte per cycle unless the output stalls; a non-final header byte gives no result.
// The result register frees the input side whenever the result is taken or the slot is empty.
// Reset (rst_ni low, asynchronous) empties both stages, starts header gathering afresh and sets
// the maximum packet length to 29000.
module length_prefixed_packet_deframer_unit import lpd_pkg::*; #(
  parameter int unsigned HeaderBytes = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LenW-1:0]   cfg_wdata_i,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic [WordW-1:0]  header_word_o,
  output logic [LenW-1:0]   packet_length_o,
  output logic              is_last_o
);

  logic [LenW-1:0]  max_len_q, max_len_d;
  logic             s1_valid;
  logic [ByteW-1:0] s1_data;
  logic             s1_take;
  res_t             res;

  assign max_len_d = cfg_we_i ? cfg_wdata_i : max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  lpd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_valid_i),
    .stall_o (rx_stall_o),
    .data_i  (rx_byte_i),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .take_i  (s1_take)
  );

  lpd_core #(
    .HeaderBytes (HeaderBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_data_i   (s1_data),
    .take_o      (s1_take),
    .max_len_i   (max_len_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign event_kind_o    = res.kind;
  assign out_byte_o      = res.data;
  assign header_word_o   = res.word;
  assign packet_length_o = res.len;
  assign is_last_o       = res.last;

endmodule

FILE: hdl/lpd_in_stage.sv
// Input register stage that holds one received byte until the core takes it.
module lpd_in_stage import lpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [ByteW-1:0] data_i,
  output logic             valid_o,
  output logic [ByteW-1:0] data_o,
  input  logic             take_i
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             ready;

  // The stage can load whenever it is empty or its byte leaves in this cycle.
  assign ready   = !valid_q || take_i;
  assign stall_o = !ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready) begin
      valid_d = valid_i;
      data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/lpd_core.sv
// Deframing state, header checks and the result register.
module lpd_core import lpd_pkg::*; #(
  parameter int unsigned HeaderBytes = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_data_i,
  output logic             take_o,
  input  logic [LenW-1:0]  max_len_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             res_o
);

  localparam int unsigned CntW = $clog2(HeaderBytes + 1);
  localparam int unsigned HdrW = ByteW * HeaderBytes;

  logic             in_body_q, in_body_d;
  logic [CntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [HdrW-1:0]  hdr_q, hdr_d;
  logic [LenW-1:0]  body_rem_q, body_rem_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;

  logic             out_free;
  logic             take;
  logic [CntW-1:0]  cnt_next;
  logic [HdrW-1:0]  hdr_next;
  logic             hdr_done;
  logic [LenW-1:0]  len;
  logic             len_bad;
  logic             produces;
  res_t             res_new;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = in_valid_i && out_free;
  assign take_o   = take;

  assign cnt_next = hdr_cnt_q + CntW'(1);
  assign hdr_next = {hdr_q[HdrW-ByteW-1:0], in_data_i};
  assign hdr_done = (cnt_next == CntW'(HeaderBytes));
  assign len      = hdr_next[HdrW-1 -: LenW];
  assign len_bad  = (len < LenW'(HeaderBytes)) || (len > max_len_i);
  assign produces = in_body_q || hdr_done;

  always_comb begin
    in_body_d  = in_body_q;
    hdr_cnt_d  = hdr_cnt_q;
    hdr_d      = hdr_q;
    body_rem_d = body_rem_q;

    res_new      = '0;
    res_new.kind = EV_BODY;

    if (in_body_q) begin
      res_new.kind = EV_BODY;
      res_new.data = in_data_i;
      res_new.last = (body_rem_q <= LenW'(1));
      if (body_rem_q <= LenW'(1)) begin
        in_body_d  = 1'b0;
        body_rem_d = '0;
      end else begin
        body_rem_d = body_rem_q - LenW'(1);
      end
    end else if (!hdr_done) begin
      hdr_d     = hdr_next;
      hdr_cnt_d = cnt_next;
    end else begin
      // A complete header always restarts the gathering count; the stored
      // bytes are overwritten in full before the next header is read.
      hdr_cnt_d    = '0;
      res_new.word = WordW'(hdr_next);
      res_new.len  = len;
      if (len_bad) begin
        res_new.kind = EV_HDR_BAD;
      end else if (len == LenW'(HeaderBytes)) begin
        res_new.kind = EV_HDR_OK;
        res_new.last = 1'b1;
      end else begin
        res_new.kind = EV_HDR_OK;
        in_body_d    = 1'b1;
        body_rem_d   = len - LenW'(HeaderBytes);
      end
    end

    if (!take) begin
      in_body_d  = in_body_q;
      hdr_cnt_d  = hdr_cnt_q;
      hdr_d      = hdr_q;
      body_rem_d = body_rem_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (out_free) begin
      out_valid_d = take && produces;
      res_d       = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q   <= 1'b0;
      hdr_cnt_q   <= '0;
      body_rem_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_body_q   <= in_body_d;
      hdr_cnt_q   <= hdr_cnt_d;
      body_rem_q  <= body_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // While passing the body, no header bytes are being gathered and bytes remain.
  a_body_no_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (hdr_cnt_q == '0) && (body_rem_q != '0))
    else $error("body state with header count or no bytes remaining");

  a_cnt_below_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q < CntW'(HeaderBytes))
    else $error("header count reached the header size");

  a_bad_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind == EV_HDR_BAD) |-> !res_q.last)
    else $error("rejected header marked as last");

  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind == EV_BODY) |-> (res_q.word == '0) && (res_q.len == '0))
    else $error("body transaction carries header fields");

  a_body_after_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !in_body_q && hdr_done && !len_bad && (len != LenW'(HeaderBytes))
    |=> in_body_q)
    else $error("accepted header with body did not enter the body state");

endmodule
